[sv/q51_pkg.sv]
package q51_pkg;

    localparam int BlockValues = 32;
    localparam int HalfValues  = 16;
    localparam logic [31:0] CanonNan = 32'h7FC0_0000;

    typedef struct packed {
        logic [15:0] scale_half;
        logic [15:0] offset_half;
        logic [31:0] high_bits;
        logic [63:0] nibbles_first;
        logic [63:0] nibbles_second;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  position;
        logic [31:0] value_bits;
        logic        last_value;
    } t_out_item;

    // Unpacked fp32 operand: class flags, sign, unbiased-plus-127 exponent, 24-bit significand.
    typedef struct packed {
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic        sign;
        logic signed [9:0] exp;
        logic [23:0] sig;
    } t_fp;

    // Widens a half to unpacked fp32 form; subnormals are normalized exactly.
    function automatic t_fp half_unpack(input logic [15:0] h);
        t_fp f;
        logic [10:0] m;
        logic [3:0] lz;
        f.sign    = h[15];
        f.is_nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        f.is_inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
        f.is_zero = (h[14:0] == 15'd0);
        if (h[14:10] == 5'd0) begin
            lz = 4'd0;
            for (int i = 9; i >= 0; i--) begin
                if (h[i] && lz == 4'd0) lz = 4'(10 - i);
            end
            m = {1'b0, h[9:0]} << lz;
            f.exp = 10'sd113 - 10'(lz);
            f.sig = {m[10:0], 13'd0};
        end else begin
            f.exp = 10'(h[14:10]) + 10'sd112;
            f.sig = {1'b1, h[9:0], 13'd0};
        end
        return f;
    endfunction

    // Rounds a sign, exponent (of the bit at position 26) and 27-bit
    // significand with sticky in bit 0 to fp32, nearest even, keeping subnormals.
    function automatic logic [31:0] fp_round(input logic s, input logic signed [10:0] e,
                                             input logic [26:0] m);
        logic [26:0] sh;
        logic signed [10:0] ee;
        logic [5:0] amt;
        logic [24:0] r;
        logic rnd;
        logic [31:0] res;
        ee = e;
        sh = m;
        if (e < 11'sd1) begin
            amt = (11'sd1 - e > 11'sd27) ? 6'd27 : 6'(11'sd1 - e);
            sh = (m >> amt) | 27'(|(m & ~(27'h7FF_FFFF << amt)));
            ee = 11'sd0;
        end
        rnd = sh[2] && (sh[1] || sh[0] || sh[3]);
        r = {1'b0, sh[26:3]} + 25'(rnd);
        if (r[24]) begin
            r = r >> 1;
            ee = ee + 11'sd1;
        end else if (ee == 11'sd0 && r[23]) begin
            ee = 11'sd1;
        end
        if (ee >= 11'sd255) res = {s, 8'hFF, 23'd0};
        else res = {s, ee[7:0], r[22:0]};
        return res;
    endfunction

endpackage

[sv/q5_1_block_dequantizer.sv]
// Dequantizes one 5-bit block into 32 fp32 values, one per cycle, in order
// 0..31, with o_item.last_value set on value 31. A block is taken when i_start is
// high and o_busy is low. o_busy stays high while values 0..30 issue and drops
// as value 31 issues, so the next block can be taken right away and blocks
// follow back to back with no gap. Each value passes through a five-stage
// pipeline (code select, multiply, product round, align and add, sum round),
// and the next block's issue overlaps the drain of the last one. Results come
// on o_valid for one cycle each; the receiver cannot stall them.
module q5_1_block_dequantizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  q51_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_valid,
    output q51_pkg::t_out_item o_item
);
    import q51_pkg::*;

    // Issue: hold the block and count positions.
    logic        r_busy, n_busy;
    logic [4:0]  r_pos;
    t_in_item    r_blk;
    t_fp         r_scale, r_offset;
    logic        w_accept;

    assign o_busy   = r_busy && (r_pos != 5'(BlockValues - 1));
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            if (r_busy) r_pos <= r_pos + 5'd1;
        end
        if (w_accept) begin
            r_blk    <= i_item;
            r_scale  <= half_unpack(i_item.scale_half);
            r_offset <= half_unpack(i_item.offset_half);
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (w_accept) n_busy = 1'b1;
        else if (r_busy && r_pos == 5'(BlockValues - 1)) n_busy = 1'b0;
    end

    // Stage 1: code select.
    logic [3:0] w_bidx;
    logic [7:0] w_byte;
    logic [4:0] w_code;
    assign w_bidx = r_pos[3:0];
    assign w_byte = w_bidx[3] ? r_blk.nibbles_second[{w_bidx[2:0], 3'd0} +: 8]
                              : r_blk.nibbles_first[{w_bidx[2:0], 3'd0} +: 8];
    assign w_code = {r_blk.high_bits[r_pos], r_pos[4] ? w_byte[7:4] : w_byte[3:0]};

    logic       r1_v;
    logic [4:0] r1_pos, r1_code;
    t_fp        r1_sc, r1_of;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= r_busy;
        r1_pos <= r_pos; r1_code <= w_code; r1_sc <= r_scale; r1_of <= r_offset;
    end

    // Stage 2: multiply the code into the significand.
    logic       r2_v;
    logic [4:0] r2_pos;
    logic [28:0] r2_prod;
    logic       r2_zero, r2_nan, r2_inf, r2_sign;
    logic signed [9:0] r2_exp;
    t_fp        r2_of;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_pos  <= r1_pos;
        r2_prod <= 29'(r1_sc.sig) * 29'(r1_code);
        r2_nan  <= r1_sc.is_nan || (r1_sc.is_inf && r1_code == 5'd0);
        r2_inf  <= r1_sc.is_inf && r1_code != 5'd0;
        r2_zero <= r1_sc.is_zero || r1_code == 5'd0;
        r2_sign <= r1_sc.sign;
        r2_exp  <= r1_sc.exp;
        r2_of   <= r1_of;
    end

    // Stage 3: normalize and round the product to fp32 (exact values fit, no subnormal).
    logic [4:0]  w_lz;
    logic [28:0] w_pn;
    logic [31:0] w_pbits;
    always_comb begin
        w_lz = 5'd0;
        for (int i = 0; i <= 28; i++) begin
            if (r2_prod[i]) w_lz = 5'(28 - i);
        end
        w_pn = r2_prod << w_lz;
        w_pbits = fp_round(r2_sign, 11'(r2_exp) + 11'sd5 - 11'(w_lz),
                           {w_pn[28:3], |w_pn[2:0]});
    end

    logic       r3_v;
    logic [4:0] r3_pos;
    t_fp        r3_p, r3_of;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= r2_v;
        r3_pos <= r2_pos;
        r3_of  <= r2_of;
        r3_p.is_nan  <= r2_nan;
        r3_p.is_inf  <= r2_inf || (!r2_nan && !r2_zero && w_pbits[30:23] == 8'hFF);
        r3_p.is_zero <= r2_zero && !r2_nan;
        r3_p.sign    <= r2_sign;
        r3_p.exp     <= 10'(w_pbits[30:23]);
        r3_p.sig     <= {1'b1, w_pbits[22:0]};
    end

    // Stage 4: align the smaller operand and add or subtract.
    logic        w_swap, w_sub;
    t_fp         w_a, w_b;
    logic [10:0] w_d;
    logic [27:0] w_bs, w_sum;
    logic [26:0] w_am;
    always_comb begin
        w_swap = (r3_of.exp > r3_p.exp) ||
                 (r3_of.exp == r3_p.exp && r3_of.sig > r3_p.sig) || r3_p.is_zero;
        if (r3_of.is_zero) w_swap = 1'b0;
        w_a = w_swap ? r3_of : r3_p;
        w_b = w_swap ? r3_p : r3_of;
        w_sub = w_a.sign ^ w_b.sign;
        w_d = 11'(w_a.exp - w_b.exp);
        w_am = {w_a.sig, 3'd0};
        if (w_b.is_zero) w_bs = 28'd0;
        else if (w_d > 11'd26) w_bs = 28'd1;
        else w_bs = 28'({w_b.sig, 3'd0} >> w_d[4:0]) |
                    28'(|({w_b.sig, 3'd0} & ~(27'h7FF_FFFF << w_d[4:0])));
        w_sum = w_sub ? ({1'b0, w_am} - w_bs) : ({1'b0, w_am} + w_bs);
    end

    logic        r4_v, r4_nan, r4_inf, r4_zero, r4_sign, r4_zsign;
    logic [4:0]  r4_pos;
    logic signed [9:0] r4_exp;
    logic [27:0] r4_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else r4_v <= r3_v;
        r4_pos  <= r3_pos;
        r4_nan  <= r3_p.is_nan || r3_of.is_nan ||
                   (r3_p.is_inf && r3_of.is_inf && r3_p.sign != r3_of.sign);
        r4_inf  <= r3_p.is_inf || r3_of.is_inf;
        r4_sign <= (r3_p.is_inf) ? r3_p.sign : (r3_of.is_inf ? r3_of.sign : w_a.sign);
        r4_zero <= (r3_p.is_zero && r3_of.is_zero) || w_sum == 28'd0;
        r4_zsign <= r3_p.is_zero && r3_of.is_zero && r3_p.sign && r3_of.sign;
        r4_exp  <= w_a.exp;
        r4_sum  <= w_sum;
    end

    // Stage 5: normalize and round the sum; special classes override.
    logic [4:0]  w_sz;
    logic [27:0] w_sn;
    logic [31:0] w_res;
    always_comb begin
        w_sz = 5'd0;
        for (int i = 0; i <= 27; i++) begin
            if (r4_sum[i]) w_sz = 5'(27 - i);
        end
        w_sn = r4_sum << w_sz;
        if (r4_nan) w_res = CanonNan;
        else if (r4_inf) w_res = {r4_sign, 8'hFF, 23'd0};
        else if (r4_zero) w_res = {r4_zsign, 31'd0};
        else w_res = fp_round(r4_sign, 11'(r4_exp) + 11'sd1 - 11'(w_sz),
                              {w_sn[27:2], |w_sn[1:0]});
    end

    logic      r5_v;
    t_out_item r5_item;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else r5_v <= r4_v;
        r5_item.position   <= r4_pos;
        r5_item.value_bits <= w_res;
        r5_item.last_value <= (r4_pos == 5'(BlockValues - 1));
    end

    assign o_valid = r5_v;
    assign o_item  = r5_item;

endmodule

[tb/sv/q5_1_block_dequantizer_test.sv]
`timescale 1ns / 100ps

module q5_1_block_dequantizer_test;
    import q51_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 20;
    localparam logic [31:0] QuietNan = 32'h7FC0_0000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_item;
    logic      o_busy;
    logic      o_valid;
    t_out_item o_item;

    t_out_item pending_values[$];
    bit        failed;
    bit        idle_on;
    int        cycle_count;

    q5_1_block_dequantizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Magnitude of a finite half in units of 2^-24, which holds every half exactly.
    function automatic longint half_units(input logic [15:0] h);
        if (h[14:10] == 5'd0) begin
            return longint'(h[9:0]);
        end
        return longint'({1'b1, h[9:0]}) << (h[14:10] - 1);
    endfunction

    // Computes one dequantized value: the product is always exact in fp32 for
    // finite halves, so only the sum needs rounding, done on exact integers.
    function automatic logic [31:0] dequant_value(input logic [4:0] code,
                                                  input logic [15:0] scale,
                                                  input logic [15:0] offset);
        logic sc_nan, sc_inf, of_nan, of_inf, s;
        longint pv, ov, n;
        longint unsigned mag, q, rem, half;
        int k, sh;
        sc_nan = (scale[14:10] == 5'h1F) && (scale[9:0] != 0);
        sc_inf = (scale[14:10] == 5'h1F) && (scale[9:0] == 0);
        of_nan = (offset[14:10] == 5'h1F) && (offset[9:0] != 0);
        of_inf = (offset[14:10] == 5'h1F) && (offset[9:0] == 0);
        if (sc_nan || of_nan) return QuietNan;
        if (sc_inf) begin
            // Zero times infinity is invalid; opposite infinities cancel to NaN.
            if (code == 5'd0) return QuietNan;
            if (of_inf && offset[15] != scale[15]) return QuietNan;
            return {scale[15], 8'hFF, 23'd0};
        end
        if (of_inf) return {offset[15], 8'hFF, 23'd0};
        pv = longint'(code) * half_units(scale);
        if (scale[15]) pv = -pv;
        ov = half_units(offset);
        if (offset[15]) ov = -ov;
        n = pv + ov;
        // An exact zero sum is negative only when both addends are negative zeros.
        if (n == 0) return {scale[15] && offset[15], 31'd0};
        s = (n < 0);
        mag = s ? -n : n;
        k = 0;
        for (int i = 0; i < 48; i++) begin
            if (mag[i]) k = i;
        end
        if (k <= 23) begin
            q = mag << (23 - k);
        end else begin
            sh = k - 23;
            q = mag >> sh;
            rem = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q = q + 1;
            if (q[24]) begin
                q = q >> 1;
                k = k + 1;
            end
        end
        return {s, 8'(k + 103), q[22:0]};
    endfunction

    // Queues the 32 values that one block must produce.
    task automatic queue_block_values(input t_in_item blk);
        t_out_item v;
        logic [7:0] byte_val;
        logic [3:0] nib;
        int b;
        for (int j = 0; j < BlockValues; j++) begin
            b = j % HalfValues;
            byte_val = (b < 8) ? blk.nibbles_first[8*b +: 8]
                               : blk.nibbles_second[8*(b-8) +: 8];
            nib = (j < HalfValues) ? byte_val[3:0] : byte_val[7:4];
            v.position = 5'(j);
            v.value_bits = dequant_value({blk.high_bits[j], nib}, blk.scale_half,
                                         blk.offset_half);
            v.last_value = (j == BlockValues - 1);
            pending_values.push_back(v);
        end
    endtask

    // Sends one block, with an optional random idle burst ahead of it.
    task automatic send_block(input t_in_item blk);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_start = 1'b1;
        i_item = blk;
        while (o_busy) @(negedge i_clk);
        queue_block_values(blk);
        @(negedge i_clk);
    endtask

    // Picks a half, often from the special encodings.
    function automatic logic [15:0] pick_half();
        logic [15:0] specials[10] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                      16'h0001, 16'h83FF, 16'h7BFF, 16'hFBFF, 16'h7C01};
        if ($urandom_range(0, 5) == 0) return specials[$urandom_range(0, 9)];
        return 16'($urandom);
    endfunction

    function automatic t_in_item random_block();
        t_in_item blk;
        blk.scale_half = pick_half();
        blk.offset_half = pick_half();
        blk.high_bits = $urandom;
        blk.nibbles_first = {$urandom, $urandom};
        blk.nibbles_second = {$urandom, $urandom};
        return blk;
    endfunction

    function automatic t_in_item make_block(input logic [15:0] sc, input logic [15:0] of,
                                            input logic [31:0] hb, input logic [63:0] nf,
                                            input logic [63:0] ns);
        t_in_item blk;
        blk.scale_half = sc;
        blk.offset_half = of;
        blk.high_bits = hb;
        blk.nibbles_first = nf;
        blk.nibbles_second = ns;
        return blk;
    endfunction

    // Field extremes: all-zero and all-one codes, largest and smallest halves.
    task automatic test_field_extremes();
        send_block(make_block(16'h0000, 16'h0000, 32'h0, 64'h0, 64'h0));
        send_block(make_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '1, '1));
        send_block(make_block(16'h7BFF, 16'h7BFF, 32'hFFFF_FFFF, '1, '1));
        send_block(make_block(16'hFBFF, 16'h7BFF, 32'hFFFF_FFFF, '1, '1));
        send_block(make_block(16'h3C00, 16'h0000, 32'hA5A5_5A5A,
                              64'h7654_3210_FEDC_BA98, 64'h0123_4567_89AB_CDEF));
        send_block(make_block(16'h0001, 16'h8001, 32'h0F0F_F0F0,
                              64'h1111_2222_4444_8888, 64'hF0F0_0F0F_3C3C_C3C3));
    endtask

    // Signed zeros, subnormals, infinities and NaN inputs.
    task automatic test_special_values();
        send_block(make_block(16'h8000, 16'h8000, 32'h0000_FFFF, 64'h0, '1));
        send_block(make_block(16'h8000, 16'h0000, 32'h0, 64'h0, 64'h0));
        send_block(make_block(16'h03FF, 16'h8200, 32'h1234_5678,
                              64'hDEAD_BEEF_0BAD_F00D, 64'h0123_4567_89AB_CDEF));
        send_block(make_block(16'h7C00, 16'h0000, 32'h8000_0001,
                              64'h0F00_000F_0000_0000, 64'h0));
        send_block(make_block(16'h7C00, 16'hFC00, 32'h5555_5555, 64'h0, 64'h0));
        send_block(make_block(16'hFC00, 16'hFC00, 32'hAAAA_AAAA, 64'h0, '1));
        send_block(make_block(16'h3C00, 16'h7C00, 32'hFFFF_0000, '1, 64'h0));
        send_block(make_block(16'h7E01, 16'h3C00, 32'h0, 64'h0, 64'h0));
        send_block(make_block(16'h3C00, 16'hFD55, 32'hFFFF_FFFF, 64'h0, 64'h0));
        // Offset cancels the product exactly, which must give positive zero.
        send_block(make_block(16'h3C00, 16'hCC00, 32'h0000_0010, 64'h0, 64'h0));
        // Wide exponent gaps force rounding of the sum.
        send_block(make_block(16'h7800, 16'h0001, 32'hFFFF_FFFF, '1, '1));
        send_block(make_block(16'h0401, 16'h6BFF, 32'h0, 64'h3333_3333_3333_3333, '1));
    endtask

    // Random blocks; the final stretch runs with no idle gaps.
    task automatic test_random_blocks(input int count);
        for (int i = 0; i < count; i++) begin
            idle_on = (i < count - 20);
            send_block(random_block());
        end
        i_start = 1'b0;
    endtask

    // Checks every strobed value against the oldest queued expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pending_values.size() == 0) begin
                $error("unexpected value at position %0d", o_item.position);
                failed = 1'b1;
            end else begin
                want = pending_values.pop_front();
                if (o_item.position !== want.position) begin
                    $error("position: expected %0d, actual %0d", want.position,
                           o_item.position);
                    failed = 1'b1;
                end
                if (o_item.value_bits !== want.value_bits) begin
                    $error("value_bits: expected %h, actual %h", want.value_bits,
                           o_item.value_bits);
                    failed = 1'b1;
                end
                if (o_item.last_value !== want.last_value) begin
                    $error("last_value: expected %b, actual %b", want.last_value,
                           o_item.last_value);
                    failed = 1'b1;
                end
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("q5_1_block_dequantizer regression: fail");
            $finish;
        end
    end

    initial begin
        failed = 1'b0;
        idle_on = 1'b1;
        cycle_count = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_field_extremes();
        test_special_values();
        test_random_blocks(92);
        while (pending_values.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        if (!failed) begin
            $display("q5_1_block_dequantizer regression: pass");
        end else begin
            $display("q5_1_block_dequantizer regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/q51_pkg.sv
sv/q5_1_block_dequantizer.sv
tb/sv/q5_1_block_dequantizer_test.sv
